@@ rtl/hfdr_pkg.sv @@
package hfdr_pkg;

  // input item operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_SWAP_AXES      = 3'd0;
  localparam logic [2:0] REG_NEGATE_FORWARD = 3'd1;
  localparam logic [2:0] REG_NEGATE_LEFT    = 3'd2;
  localparam logic [2:0] REG_METRES_PER_CNT = 3'd3;
  localparam logic [2:0] REG_OFFSET_FORWARD = 3'd4;
  localparam logic [2:0] REG_OFFSET_LEFT    = 3'd5;
  localparam logic [2:0] REG_HEADING_ENABLE = 3'd6;
  localparam logic [2:0] REG_FLOW_ENABLE    = 3'd7;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam int FULL_TURN = 5760;
  localparam int HALF_TURN = 2880;

  // arctangent table, 2^32 per turn
  function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd536870912;
      5'd1:  r = 32'sd316933406;
      5'd2:  r = 32'sd167458907;
      5'd3:  r = 32'sd85004756;
      5'd4:  r = 32'sd42667331;
      5'd5:  r = 32'sd21354465;
      5'd6:  r = 32'sd10680862;
      5'd7:  r = 32'sd5340245;
      5'd8:  r = 32'sd2670163;
      5'd9:  r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41722;
      5'd15: r = 32'sd20861;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2608;
      5'd19: r = 32'sd1304;
      5'd20: r = 32'sd652;
      5'd21: r = 32'sd326;
      5'd22: r = 32'sd163;
      5'd23: r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // back-end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CORD_D,
    BK_BODY_F1,
    BK_BODY_F2,
    BK_BODY_L1,
    BK_BODY_L2,
    BK_CORD_M,
    BK_WX1,
    BK_WX2,
    BK_WY1,
    BK_WY2,
    BK_OUT
  } bk_state_t;

  // command handed from front to back
  typedef struct packed {
    logic        clear;      // reset item: zero the pose
    logic        flow;       // integrate flow
    logic [31:0] d_ang;      // step turn, 32-bit binary angle
    logic [31:0] mid_ang;    // mid-step angle, 32-bit binary angle
    logic [31:0] theta32;    // new heading, 32-bit binary angle
    logic signed [16:0] fwd; // forward counts after sign
    logic signed [16:0] lft; // left counts after sign
  } hfdr_cmd_t;

endpackage

@@ rtl/hfdr_cordic.sv @@
// iterative cordic, one rotation step per cycle, q30 sine and cosine
module hfdr_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic               flip;
  logic               busy;
  logic [4:0]         step;
  logic signed [31:0] za;
  logic signed [31:0] zf;
  logic               need_flip;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;

  // fold angles beyond a quarter turn by a half turn
  always_comb begin
    za        = $signed(angle);
    need_flip = (za > 32'sh4000_0000) || (za < -32'sh4000_0000);
    zf        = need_flip ? $signed(angle + 32'h8000_0000) : za;
    xs        = x >>> step;
    ys        = y >>> step;
    at        = 34'(hfdr_pkg::atan_lut(step));
  end

  // rotation steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= 34'(hfdr_pkg::CORDIC_GAIN);
        y    <= '0;
        z    <= 34'(zf);
        flip <= need_flip;
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        if (step == 5'(hfdr_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 5'd1;
        end
      end
    end
  end

  assign cos_q = flip ? -x[31:0] : x[31:0];
  assign sin_q = flip ? -y[31:0] : y[31:0];

endmodule

@@ rtl/hfdr_front.sv @@
// front part: heading bookkeeping and count mapping, one item a cycle while the queue has room
module hfdr_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [12:0]           heading_raw,
  input  logic                  heading_valid,
  input  logic signed [15:0]    flow_dx,
  input  logic signed [15:0]    flow_dy,
  input  logic                  swap_axes,
  input  logic                  negate_forward,
  input  logic                  negate_left,
  input  logic                  heading_enable,
  input  logic                  flow_enable,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output hfdr_pkg::hfdr_cmd_t   cmd
);

  localparam int CONV_W = 13 + ANGLE_BITS + 1;
  // full turn is 45 * 2^7: drop the low 7 bits, then multiply by a reciprocal of 45
  localparam int LOW_SH = 7;
  localparam int DIV_K  = hfdr_pkg::FULL_TURN / 128;
  localparam int Q_W    = CONV_W - LOW_SH;
  localparam int RCP_SH = Q_W + 6;
  localparam int RCP_W  = Q_W + 1;
  localparam int PROD_W = Q_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(DIV_K - 1)) / 64'(DIV_K));

  logic [ANGLE_BITS-1:0] heading_angle;
  logic [ANGLE_BITS-1:0] heading_zero;
  logic [CONV_W-1:0]     num;
  logic [PROD_W-1:0]     quo;
  logic [ANGLE_BITS-1:0] conv;
  logic [ANGLE_BITS-1:0] ccw;
  logic [ANGLE_BITS-1:0] nw;
  logic [ANGLE_BITS-1:0] d;
  logic [ANGLE_BITS-1:0] mid;
  logic                  head_ok;
  logic signed [16:0]    fwd;
  logic signed [16:0]    lft;
  logic                  take;
  logic [1:0]            q_cnt;
  logic                  q_wr;
  logic                  q_rd;
  logic                  q_ptr_w;
  logic                  q_ptr_r;
  hfdr_pkg::hfdr_cmd_t   q_mem [2];
  hfdr_pkg::hfdr_cmd_t   cmd_new;

  // heading conversion, reciprocal multiplication by the constant full turn
  always_comb begin
    num     = (CONV_W'(heading_raw) << ANGLE_BITS) + CONV_W'(hfdr_pkg::HALF_TURN);
    quo     = PROD_W'(num[CONV_W-1:LOW_SH]) * PROD_W'(RCP);
    conv    = ANGLE_BITS'(quo >> RCP_SH);
    ccw     = -conv;
    head_ok = heading_enable & heading_valid;
    nw      = ccw - heading_zero;
    d       = head_ok ? nw - heading_angle : '0;
    mid     = heading_angle + {d[ANGLE_BITS-1], d[ANGLE_BITS-1:1]};
  end

  // count mapping
  always_comb begin
    fwd = swap_axes ? 17'(flow_dy) : 17'(flow_dx);
    lft = swap_axes ? 17'(flow_dx) : 17'(flow_dy);
    if (negate_forward) fwd = -fwd;
    if (negate_left) lft = -lft;
  end

  always_comb begin
    cmd_new.clear   = (operation == hfdr_pkg::OP_RESET);
    cmd_new.flow    = flow_enable;
    cmd_new.d_ang   = {d, {(32 - ANGLE_BITS){1'b0}}} >> 0;
    cmd_new.mid_ang = {mid, {(32 - ANGLE_BITS){1'b0}}};
    cmd_new.theta32 = cmd_new.clear ? 32'd0 :
                      {(head_ok ? nw : heading_angle), {(32 - ANGLE_BITS){1'b0}}};
    cmd_new.fwd     = fwd;
    cmd_new.lft     = lft;
  end

  assign in_ready = (q_cnt != 2'd2);
  assign take     = in_valid & in_ready;
  assign q_wr     = take;
  assign q_rd     = cmd_valid & cmd_ready;

  // heading state
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_angle <= '0;
      heading_zero  <= '0;
    end else if (take) begin
      if (operation == hfdr_pkg::OP_RESET) begin
        heading_angle <= '0;
        if (head_ok) heading_zero <= ccw;
      end else if (head_ok) begin
        heading_angle <= nw;
      end
    end
  end

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (q_wr) q_mem[q_ptr_w] <= cmd_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt   <= '0;
      q_ptr_w <= 1'b0;
      q_ptr_r <= 1'b0;
    end else begin
      if (q_wr) q_ptr_w <= ~q_ptr_w;
      if (q_rd) q_ptr_r <= ~q_ptr_r;
      q_cnt <= q_cnt + 2'(q_wr) - 2'(q_rd);
    end
  end

  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd       = q_mem[q_ptr_r];

  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_cnt <= 2'd2)
    else $error("command queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q_cnt == 2'd2) |-> !q_wr)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (q_cnt == 2'd0) |-> !q_rd)
    else $error("command queue read while empty");

endmodule

@@ rtl/hfdr_back.sv @@
// back part: arc correction, rotation and accumulation
module hfdr_back #(
  parameter int POS_BITS   = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  hfdr_pkg::hfdr_cmd_t cmd,
  input  logic [15:0]         metres_per_count,
  input  logic signed [16:0]  sensor_offset_forward,
  input  logic signed [16:0]  sensor_offset_left,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         pos_x,
  output logic [31:0]         pos_y,
  output logic [15:0]         theta
);

  hfdr_pkg::bk_state_t state;
  hfdr_pkg::bk_state_t state_next;
  hfdr_pkg::hfdr_cmd_t cur;

  logic [POS_BITS-1:0]  acc_x;
  logic [POS_BITS-1:0]  acc_y;
  logic signed [63:0]   acc;       // product sum
  logic signed [31:0]   c_q;
  logic signed [31:0]   s_q;
  logic signed [31:0]   c_t;
  logic signed [31:0]   s_t;
  logic signed [47:0]   fb;
  logic signed [47:0]   lb;
  logic signed [63:0]   prod;
  logic signed [33:0]   m_a;
  logic signed [31:0]   m_b;
  logic                 cor_start;
  logic [31:0]          cor_angle;
  logic                 cor_done;
  logic signed [31:0]   cor_c;
  logic signed [31:0]   cor_s;
  logic signed [63:0]   fcnt;
  logic signed [63:0]   lcnt;
  logic signed [63:0]   rnd22;

  hfdr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_q (cor_c),
    .sin_q (cor_s)
  );

  // shared multiplier operands, one product per cycle
  always_comb begin
    m_a = '0;
    m_b = '0;
    case (state)
      hfdr_pkg::BK_BODY_F1: begin m_a = 34'(c_q) - 34'sd1073741824;
                                  m_b = 32'(sensor_offset_forward); end
      hfdr_pkg::BK_BODY_F2: begin m_a = 34'(s_q); m_b = 32'(sensor_offset_left); end
      hfdr_pkg::BK_BODY_L1: begin m_a = 34'(s_q); m_b = 32'(sensor_offset_forward); end
      hfdr_pkg::BK_BODY_L2: begin m_a = 34'(c_q) - 34'sd1073741824;
                                  m_b = 32'(sensor_offset_left); end
      hfdr_pkg::BK_WX1:     begin m_a = 34'(fb); m_b = c_t; end
      hfdr_pkg::BK_WX2:     begin m_a = 34'(lb); m_b = s_t; end
      hfdr_pkg::BK_WY1:     begin m_a = 34'(fb); m_b = s_t; end
      hfdr_pkg::BK_WY2:     begin m_a = 34'(lb); m_b = c_t; end
      default: ;
    endcase
    prod  = m_a * m_b;
    fcnt  = (64'(cur.fwd) * 64'($signed({1'b0, metres_per_count}))) <<< 22;
    lcnt  = (64'(cur.lft) * 64'($signed({1'b0, metres_per_count}))) <<< 22;
    rnd22 = (acc + 64'sd2097152) >>> 22;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hfdr_pkg::BK_IDLE:
        if (cmd_valid) state_next = (cmd.clear || !cmd.flow) ? hfdr_pkg::BK_OUT
                                                              : hfdr_pkg::BK_CORD_D;
      hfdr_pkg::BK_CORD_D:  if (cor_done) state_next = hfdr_pkg::BK_BODY_F1;
      hfdr_pkg::BK_BODY_F1: state_next = hfdr_pkg::BK_BODY_F2;
      hfdr_pkg::BK_BODY_F2: state_next = hfdr_pkg::BK_BODY_L1;
      hfdr_pkg::BK_BODY_L1: state_next = hfdr_pkg::BK_BODY_L2;
      hfdr_pkg::BK_BODY_L2: state_next = hfdr_pkg::BK_CORD_M;
      hfdr_pkg::BK_CORD_M:  if (cor_done) state_next = hfdr_pkg::BK_WX1;
      hfdr_pkg::BK_WX1:     state_next = hfdr_pkg::BK_WX2;
      hfdr_pkg::BK_WX2:     state_next = hfdr_pkg::BK_WY1;
      hfdr_pkg::BK_WY1:     state_next = hfdr_pkg::BK_WY2;
      hfdr_pkg::BK_WY2:     state_next = hfdr_pkg::BK_OUT;
      hfdr_pkg::BK_OUT:     if (!out_valid || out_ready) state_next = hfdr_pkg::BK_IDLE;
      default:              state_next = hfdr_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready = (state == hfdr_pkg::BK_IDLE);
    cor_start = 1'b0;
    cor_angle = cur.d_ang;
    if (state == hfdr_pkg::BK_IDLE && cmd_valid && !cmd.clear && cmd.flow) begin
      cor_start = 1'b1;
      cor_angle = cmd.d_ang;
    end else if (state == hfdr_pkg::BK_BODY_L2) begin
      cor_start = 1'b1;
      cor_angle = cur.mid_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= hfdr_pkg::BK_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x <= '0;
      acc_y <= '0;
    end else begin
      case (state)
        hfdr_pkg::BK_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.clear) begin
              acc_x <= '0;
              acc_y <= '0;
            end
          end
        end
        hfdr_pkg::BK_CORD_D: begin
          c_q <= cor_c;
          s_q <= cor_s;
          acc <= fcnt;
        end
        hfdr_pkg::BK_BODY_F1: acc <= acc - prod;
        hfdr_pkg::BK_BODY_F2: begin
          fb  <= 48'(((acc + prod) + 64'sd2097152) >>> 22);
          acc <= lcnt;
        end
        hfdr_pkg::BK_BODY_L1: acc <= acc - prod;
        hfdr_pkg::BK_BODY_L2: acc <= acc - prod;
        hfdr_pkg::BK_CORD_M: begin
          lb  <= 48'(rnd22);
          c_t <= cor_c;
          s_t <= cor_s;
        end
        hfdr_pkg::BK_WX1: acc <= prod;
        hfdr_pkg::BK_WX2: begin
          acc_x <= acc_x + POS_BITS'(((acc - prod) + 64'sh20_0000_0000) >>> 38);
        end
        hfdr_pkg::BK_WY1: acc <= prod;
        hfdr_pkg::BK_WY2: acc_y <= acc_y + POS_BITS'(((acc + prod) + 64'sh20_0000_0000) >>> 38);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == hfdr_pkg::BK_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        pos_x     <= 32'($signed(acc_x));
        pos_y     <= 32'($signed(acc_y));
        theta     <= cur.theta32[31:16];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before taken");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_ready && cmd_valid) |-> state == hfdr_pkg::BK_IDLE)
    else $error("command taken outside idle");
  a_cordic_wait: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == hfdr_pkg::BK_CORD_D || state == hfdr_pkg::BK_CORD_M))
    else $error("cordic finished outside a wait state");

endmodule

@@ rtl/heading_flow_dead_reckoning.sv @@
// a flow update passes through the command queue, two cordic runs, the multiply states
//   and the output register before its result is valid
// the back end finishes one item, with its two cordic runs, before it takes the next
// reset items and items with flow disabled skip the cordic runs and the multiplies
// result stalls hold the back end; the two-entry queue lets the front accept until full
// synchronous active-high rst clears pose, heading offset, queue; loads config defaults
module heading_flow_dead_reckoning #(
  parameter int ANGLE_BITS = 16,
  parameter int POS_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // operation, heading_raw, heading_valid, flow_dx, flow_dy
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // pos_x, pos_y, theta
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic               swap_axes;
  logic               negate_forward;
  logic               negate_left;
  logic [15:0]        metres_per_count;
  logic signed [16:0] sensor_offset_forward;
  logic signed [16:0] sensor_offset_left;
  logic               heading_enable;
  logic               flow_enable;
  logic               cmd_valid;
  logic               cmd_ready;
  hfdr_pkg::hfdr_cmd_t cmd;
  logic [31:0]        pos_x;
  logic [31:0]        pos_y;
  logic [15:0]        theta;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_axes             <= 1'b1;
      negate_forward        <= 1'b1;
      negate_left           <= 1'b1;
      metres_per_count      <= 16'd2819;
      sensor_offset_forward <= -17'sd13796;
      sensor_offset_left    <= -17'sd9060;
      heading_enable        <= 1'b1;
      flow_enable           <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        hfdr_pkg::REG_SWAP_AXES:      swap_axes             <= cfg_data[0];
        hfdr_pkg::REG_NEGATE_FORWARD: negate_forward        <= cfg_data[0];
        hfdr_pkg::REG_NEGATE_LEFT:    negate_left           <= cfg_data[0];
        hfdr_pkg::REG_METRES_PER_CNT: metres_per_count      <= cfg_data[15:0];
        hfdr_pkg::REG_OFFSET_FORWARD: sensor_offset_forward <= $signed(cfg_data);
        hfdr_pkg::REG_OFFSET_LEFT:    sensor_offset_left    <= $signed(cfg_data);
        hfdr_pkg::REG_HEADING_ENABLE: heading_enable        <= cfg_data[0];
        hfdr_pkg::REG_FLOW_ENABLE:    flow_enable           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hfdr_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .operation      (s_tdata[0]),
    .heading_raw    (s_tdata[13:1]),
    .heading_valid  (s_tdata[14]),
    .flow_dx        ($signed(s_tdata[30:15])),
    .flow_dy        ($signed(s_tdata[46:31])),
    .swap_axes      (swap_axes),
    .negate_forward (negate_forward),
    .negate_left    (negate_left),
    .heading_enable (heading_enable),
    .flow_enable    (flow_enable),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd)
  );

  hfdr_back #(.POS_BITS(POS_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk                   (clk),
    .rst                   (rst),
    .cmd_valid             (cmd_valid),
    .cmd_ready             (cmd_ready),
    .cmd                   (cmd),
    .metres_per_count      (metres_per_count),
    .sensor_offset_forward (sensor_offset_forward),
    .sensor_offset_left    (sensor_offset_left),
    .out_valid             (m_tvalid),
    .out_ready             (m_tready),
    .pos_x                 (pos_x),
    .pos_y                 (pos_y),
    .theta                 (theta)
  );

  assign m_tdata = {theta, pos_y, pos_x};

endmodule

@@ dv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  heading_flow_dead_reckoning dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [15:0] theta;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  // predictor copy of registers and pose
  logic        swap_r, neg_f_r, neg_l_r, head_en_r, flow_en_r;
  logic [15:0] mpc_r;
  logic signed [16:0] off_f_r, off_l_r;
  logic [31:0] acc_x, acc_y;
  logic [15:0] head_ang, head_zero;

  pose_t pose_q[$];
  int    errors = 0;
  int    n_items = 0, n_results = 0, n_resets = 0, n_cfg = 0;
  int    cycles = 0;
  bit    quiet = 1'b0;

  const longint ATAN[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  // result check
  always @(posedge clk) begin
    pose_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pose_q.size() == 0) begin
        report_mismatch("unexpected item", longint'(got.pos_x), 0);
      end else begin
        want = pose_q.pop_front();
        if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.theta !== want.theta) report_mismatch("theta", got.theta, want.theta);
      end
      n_results++;
    end
  end

  // cordic sine and cosine, Q30
  task automatic cordic(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      z = longint'($signed(ang + 32'h8000_0000));
      flip = 1'b1;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN[i];
      end else begin
        x += ys; y -= xs; z += ATAN[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  // pose update for one accepted item
  task automatic predict_pose(input logic op, input logic [12:0] raw, input logic hv,
                              input logic signed [15:0] dx, input logic signed [15:0] dy);
    logic [15:0] conv, ccw, nw, mid;
    longint d, fwd, lft, c, s, ct, st, cm, fb, lb, wx, wy, of, ol, mpc;
    bit ok;
    pose_t p;
    conv = 16'((({19'd0, raw} << 16) + 32'd2880) / 32'd5760);
    ccw = -conv;
    ok = head_en_r && hv;
    if (op == hfdr_pkg::OP_RESET) begin
      acc_x = '0; acc_y = '0; head_ang = '0;
      if (ok) head_zero = ccw;
    end else begin
      d = 0;
      mid = head_ang;
      if (ok) begin
        nw = ccw - head_zero;
        d = longint'($signed(16'(nw - head_ang)));
        mid = head_ang + 16'(d >>> 1);
        head_ang = nw;
      end
      if (flow_en_r) begin
        fwd = swap_r ? longint'(dy) : longint'(dx);
        lft = swap_r ? longint'(dx) : longint'(dy);
        if (neg_f_r) fwd = -fwd;
        if (neg_l_r) lft = -lft;
        mpc = longint'(mpc_r);
        of = longint'(off_f_r);
        ol = longint'(off_l_r);
        cordic({16'(d), 16'd0}, c, s);
        cm = c - (64'sd1 <<< 30);
        fb = fwd * mpc * (64'sd1 <<< 22) - (cm * of - s * ol);
        lb = lft * mpc * (64'sd1 <<< 22) - (s * of + cm * ol);
        fb = (fb + (64'sd1 <<< 21)) >>> 22;
        lb = (lb + (64'sd1 <<< 21)) >>> 22;
        cordic({mid, 16'd0}, ct, st);
        wx = (fb * ct - lb * st + (64'sd1 <<< 37)) >>> 38;
        wy = (fb * st + lb * ct + (64'sd1 <<< 37)) >>> 38;
        acc_x = acc_x + 32'(wx);
        acc_y = acc_y + 32'(wy);
      end
    end
    p.pos_x = acc_x;
    p.pos_y = acc_y;
    p.theta = head_ang;
    pose_q.push_back(p);
  endtask

  task automatic send_item(input logic op, input logic [12:0] raw, input logic hv,
                           input logic [15:0] dx, input logic [15:0] dy);
    while (!quiet && $urandom_range(99) < 16) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {1'b0, dy, dx, hv, raw, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_pose(op, raw, hv, dx, dy);
    n_items++;
    if (op == hfdr_pkg::OP_RESET) n_resets++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // wait until all results are in, then let the back end settle
  task automatic wait_idle();
    while (pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [16:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      hfdr_pkg::REG_SWAP_AXES:      swap_r = val[0];
      hfdr_pkg::REG_NEGATE_FORWARD: neg_f_r = val[0];
      hfdr_pkg::REG_NEGATE_LEFT:    neg_l_r = val[0];
      hfdr_pkg::REG_METRES_PER_CNT: mpc_r = val[15:0];
      hfdr_pkg::REG_OFFSET_FORWARD: off_f_r = val;
      hfdr_pkg::REG_OFFSET_LEFT:    off_l_r = val;
      hfdr_pkg::REG_HEADING_ENABLE: head_en_r = val[0];
      hfdr_pkg::REG_FLOW_ENABLE:    flow_en_r = val[0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic cfg_all(input bit sw, input bit nf, input bit nl, input logic [15:0] mpc,
                         input logic [16:0] of, input logic [16:0] ol,
                         input bit he, input bit fe);
    wait_idle();
    cfg_write(hfdr_pkg::REG_SWAP_AXES, 17'(sw));
    cfg_write(hfdr_pkg::REG_NEGATE_FORWARD, 17'(nf));
    cfg_write(hfdr_pkg::REG_NEGATE_LEFT, 17'(nl));
    cfg_write(hfdr_pkg::REG_METRES_PER_CNT, 17'(mpc));
    cfg_write(hfdr_pkg::REG_OFFSET_FORWARD, of);
    cfg_write(hfdr_pkg::REG_OFFSET_LEFT, ol);
    cfg_write(hfdr_pkg::REG_HEADING_ENABLE, 17'(he));
    cfg_write(hfdr_pkg::REG_FLOW_ENABLE, 17'(fe));
  endtask

  // reset defaults, extremes of counts and heading, half-turn step
  task automatic test_directed();
    send_item(hfdr_pkg::OP_RESET, 13'd0, 1'b1, 16'h0, 16'h0);
    send_item(hfdr_pkg::OP_UPDATE, 13'd0, 1'b1, 16'h7fff, 16'h8000);
    send_item(hfdr_pkg::OP_UPDATE, 13'd2880, 1'b1, 16'h8000, 16'h7fff);
    send_item(hfdr_pkg::OP_UPDATE, 13'd0, 1'b1, 16'hffff, 16'h0001);
    send_item(hfdr_pkg::OP_UPDATE, 13'd5759, 1'b1, 16'h8000, 16'h8000);
    send_item(hfdr_pkg::OP_UPDATE, 13'd8191, 1'b1, 16'h7fff, 16'h7fff);
    send_item(hfdr_pkg::OP_UPDATE, 13'd1440, 1'b0, 16'h1234, 16'hedcb);
    send_item(hfdr_pkg::OP_RESET, 13'd4000, 1'b1, 16'h7fff, 16'h7fff);
    send_item(hfdr_pkg::OP_UPDATE, 13'd4100, 1'b1, 16'h0100, 16'hff00);
    send_item(hfdr_pkg::OP_RESET, 13'd100, 1'b0, 16'h0, 16'h0);
    send_item(hfdr_pkg::OP_UPDATE, 13'd6000, 1'b1, 16'h0000, 16'h0000);
    // heading disabled, offsets and scale at extremes
    cfg_all(1'b0, 1'b0, 1'b0, 16'hffff, 17'h10000, 17'h0ffff, 1'b0, 1'b1);
    send_item(hfdr_pkg::OP_UPDATE, 13'd3000, 1'b1, 16'h8000, 16'h7fff);
    send_item(hfdr_pkg::OP_RESET, 13'd3000, 1'b1, 16'h0, 16'h0);
    cfg_all(1'b0, 1'b0, 1'b0, 16'hffff, 17'h0ffff, 17'h10000, 1'b1, 1'b1);
    send_item(hfdr_pkg::OP_UPDATE, 13'd2880, 1'b1, 16'h7fff, 16'h8000);
    send_item(hfdr_pkg::OP_UPDATE, 13'd5760, 1'b1, 16'h8000, 16'h7fff);
    cfg_all(1'b1, 1'b1, 1'b0, 16'd0, 17'h10000, 17'h10000, 1'b1, 1'b0);
    send_item(hfdr_pkg::OP_UPDATE, 13'd1000, 1'b1, 16'h7fff, 16'h7fff);
    send_item(hfdr_pkg::OP_UPDATE, 13'd4000, 1'b1, 16'h8000, 16'h8000);
  endtask

  // random items under one register setting
  task automatic test_random(input int count);
    logic [12:0] raw;
    logic [15:0] dx, dy;
    raw = 13'($urandom_range(5759));
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 40) quiet = 1'b1;
      if (i % 100 == 70) quiet = 1'b0;
      case ($urandom_range(9))
        0: raw = 13'($urandom_range(8191));
        1, 2, 3: raw = 13'($urandom_range(5759));
        default: raw = 13'((int'(raw) + $urandom_range(400) + 5560) % 5760);
      endcase
      if ($urandom_range(3) == 0) begin
        dx = 16'($urandom);
        dy = 16'($urandom);
      end else begin
        dx = 16'(int'($urandom_range(400)) - 200);
        dy = 16'(int'($urandom_range(400)) - 200);
      end
      send_item(($urandom_range(19) == 0) ? hfdr_pkg::OP_RESET : hfdr_pkg::OP_UPDATE, raw,
                ($urandom_range(9) != 0), dx, dy);
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_settings();
    test_random(250);
    cfg_all(1'b0, 1'b1, 1'b0, 16'($urandom), 17'($urandom), 17'($urandom), 1'b1, 1'b1);
    test_random(250);
    cfg_all(1'b1, 1'b0, 1'b1, 16'hffff, 17'h10000, 17'h0ffff, 1'b1, 1'b1);
    test_random(200);
    cfg_all(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
            16'($urandom), 17'($urandom), 17'($urandom),
            $urandom_range(3) != 0, $urandom_range(3) != 0);
    test_random(150);
    cfg_all(1'b0, 1'b0, 1'b1, 16'($urandom), 17'($urandom), 17'($urandom), 1'b1, 1'b1);
    test_random(150);
  endtask

  initial begin
    swap_r = 1'b1; neg_f_r = 1'b1; neg_l_r = 1'b1;
    mpc_r = 16'd2819;
    off_f_r = -17'sd13796; off_l_r = -17'sd9060;
    head_en_r = 1'b1; flow_en_r = 1'b1;
    acc_x = '0; acc_y = '0; head_ang = '0; head_zero = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    cfg_all(1'b1, 1'b1, 1'b1, 16'd2819, -17'sd13796, -17'sd9060, 1'b1, 1'b1);
    test_random_settings();
    wait_idle();
    $display("sent %0d items (%0d pose resets), checked %0d results, %0d register writes",
             n_items, n_resets, n_results, n_cfg);
    $display("%0d mismatches", errors);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
